@@ src/prq_pkg.sv @@
package prq_pkg;

  localparam int ID_W  = 8;
  localparam int PRI_W = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REPRIO = 2'd2,
    OP_PEEK   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_NOT_FOUND = 2'd2
  } error_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_SLOT  = 7'b0000100,
    S_FRONT = 7'b0001000,
    S_SHUP  = 7'b0010000,
    S_SHDN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
  } entry_t;

  localparam int ENTRY_W = PRI_W + ID_W;

endpackage

@@ src/prq_ram.sv @@
module prq_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/priority_ready_queue.sv @@
// steps from accept to result valid: preempt check reads the front; pop also shifts up;
//   insert finds its slot, then shifts down; reprioritize finds the id, shifts up, then
//   inserts (stopping after the search when the id is absent); an empty-queue pop or
//   preempt check and an insert while full go straight to the result; entry memory has
// one read and one write port; one transaction at a time, the next taken once the result
// is registered; rst (synchronous) empties the queue and clears m_axis_tvalid, not entry memory
module priority_ready_queue #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int PRIORITY_MAX = 63,
  localparam int AW     = $clog2(QUEUE_DEPTH),
  localparam int CW     = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_B  = 18 + CW,
  localparam int OUT_W  = ((OUT_B + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // thread_id [7:0], priority_value [13:8], zero fill
  input  logic [15:0]      s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // out_id [7:0], out_priority [13:8], queue_empty [14], preempt [15],
  // error_code [17:16], entry_count [18+CW-1:18], zero fill
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam logic [7:0] PRI_CAP = 8'(PRIORITY_MAX);

  prq_pkg::state_t  state;
  prq_pkg::opcode_t op;
  prq_pkg::entry_t  rd_entry;
  prq_pkg::entry_t  wr_entry;
  prq_pkg::error_t  res_err;

  logic [prq_pkg::ID_W-1:0]  id_q;
  logic [prq_pkg::PRI_W-1:0] pri_q;
  logic [prq_pkg::PRI_W-1:0] pri_in;
  logic [prq_pkg::PRI_W-1:0] pri_sat;
  logic [prq_pkg::ID_W-1:0]  res_id;
  logic [prq_pkg::PRI_W-1:0] res_pri;
  logic                      res_pre;

  logic [CW-1:0] occ;
  logic [CW-1:0] cnt;
  logic [CW-1:0] pos;
  logic [CW-1:0] cnt_p1;
  logic [CW-1:0] cnt_p2;
  logic [CW-1:0] cnt_m2;
  logic [CW-1:0] occ_m1;

  logic          slot_done;
  logic          shup_done;
  logic          s_fire;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign s_axis_tready = (state == prq_pkg::S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign pri_in  = s_axis_tdata[13:8];
  assign pri_sat = ({2'b00, pri_in} > PRI_CAP) ? PRI_CAP[prq_pkg::PRI_W-1:0] : pri_in;

  assign cnt_p1 = cnt + CW'(1);
  assign cnt_p2 = cnt + CW'(2);
  assign cnt_m2 = cnt - CW'(2);
  assign occ_m1 = occ - CW'(1);

  assign slot_done = (cnt >= occ) || (rd_entry.pri < pri_q);
  assign shup_done = (cnt_p1 >= occ);

  always_comb begin
    we       = 1'b0;
    waddr    = cnt[AW-1:0];
    wr_entry = rd_entry;
    raddr    = '0;
    case (state)
      prq_pkg::S_FIND: begin
        raddr = cnt_p1[AW-1:0];
      end
      prq_pkg::S_SLOT: begin
        raddr = slot_done ? occ_m1[AW-1:0] : cnt_p1[AW-1:0];
      end
      prq_pkg::S_FRONT: begin
        raddr = AW'(1);
      end
      prq_pkg::S_SHUP: begin
        we    = !shup_done;
        raddr = shup_done ? '0 : cnt_p2[AW-1:0];
      end
      prq_pkg::S_SHDN: begin
        we    = 1'b1;
        raddr = cnt_m2[AW-1:0];
        if (cnt == pos) begin
          wr_entry.id  = id_q;
          wr_entry.pri = pri_q;
        end
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  prq_ram #(
    .WIDTH(prq_pkg::ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wr_entry),
    .raddr(raddr),
    .rdata(rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= prq_pkg::S_IDLE;
      occ           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == prq_pkg::S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        prq_pkg::S_IDLE: begin
          if (s_fire) begin
            op      <= prq_pkg::opcode_t'(s_axis_tuser);
            id_q    <= s_axis_tdata[7:0];
            pri_q   <= pri_sat;
            res_id  <= '0;
            res_pri <= '0;
            res_pre <= 1'b0;
            cnt     <= '0;
            case (prq_pkg::opcode_t'(s_axis_tuser))
              prq_pkg::OP_INSERT: begin
                if (occ == CW'(QUEUE_DEPTH)) begin
                  res_err <= prq_pkg::ERR_FULL;
                  state   <= prq_pkg::S_DONE;
                end else begin
                  res_err <= prq_pkg::ERR_OK;
                  state   <= prq_pkg::S_SLOT;
                end
              end
              prq_pkg::OP_REPRIO: begin
                res_err <= prq_pkg::ERR_OK;
                state   <= prq_pkg::S_FIND;
              end
              default: begin
                res_err <= prq_pkg::ERR_OK;
                state   <= (occ == '0) ? prq_pkg::S_DONE : prq_pkg::S_FRONT;
              end
            endcase
          end
        end
        prq_pkg::S_FIND: begin
          if (cnt >= occ) begin
            res_err <= prq_pkg::ERR_NOT_FOUND;
            state   <= prq_pkg::S_DONE;
          end else if (rd_entry.id == id_q) begin
            state <= prq_pkg::S_SHUP;
          end else begin
            cnt <= cnt_p1;
          end
        end
        prq_pkg::S_SLOT: begin
          if (slot_done) begin
            pos   <= cnt;
            cnt   <= occ;
            state <= prq_pkg::S_SHDN;
          end else begin
            cnt <= cnt_p1;
          end
        end
        prq_pkg::S_FRONT: begin
          res_id  <= rd_entry.id;
          res_pri <= rd_entry.pri;
          if (op == prq_pkg::OP_PEEK) begin
            res_pre <= (rd_entry.pri > pri_q);
            state   <= prq_pkg::S_DONE;
          end else begin
            cnt   <= '0;
            state <= prq_pkg::S_SHUP;
          end
        end
        prq_pkg::S_SHUP: begin
          if (shup_done) begin
            occ <= occ_m1;
            cnt <= '0;
            state <= (op == prq_pkg::OP_POP) ? prq_pkg::S_DONE : prq_pkg::S_SLOT;
          end else begin
            cnt <= cnt_p1;
          end
        end
        prq_pkg::S_SHDN: begin
          if (cnt == pos) begin
            occ   <= occ + CW'(1);
            state <= prq_pkg::S_DONE;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        prq_pkg::S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= prq_pkg::S_IDLE;
          end
        end
        default: begin
          state <= prq_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == prq_pkg::S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= OUT_W'({occ, res_err, res_pre, (occ == '0), res_pri, res_id});
    end
  end

endmodule

@@ src/prq_checker.sv @@
module prq_props #(
  parameter int QUEUE_DEPTH = 64,
  localparam int CW    = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_B = 18 + CW,
  localparam int OUT_W = ((OUT_B + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one transaction in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[14] == (m_axis_tdata[18+CW-1:18] == '0)))
    else $error("queue_empty disagrees with entry_count");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[18+CW-1:18] <= CW'(QUEUE_DEPTH)))
    else $error("entry_count above depth");

  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[17:16] != prq_pkg::ERR_OK |->
      m_axis_tdata[7:0] == '0 && m_axis_tdata[15] == 1'b0)
    else $error("failed operation returned an entry");

endmodule

bind priority_ready_queue prq_props #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_prq_props (.*);
